// ===== hw/rtl/tdp_pkg.sv =====
// Package for the trial division prime test: widths, and the command and
// status bundles that pass between controller and datapath.
// No dependencies.
package tdp_pkg;

   // Width of the tested number; bit WIDTH-1 is the sign. Range 8..64.
   localparam int WIDTH   = 32;
   // Width of the req_value port
   localparam int VALUE_W = 32;
   // Magnitude bits of a non-negative value
   localparam int NB      = WIDTH - 1;
   // Divisor and remainder width: holds sqrt(2^NB) + 2
   localparam int D_W     = WIDTH / 2 + 1;
   // Bit counter of the remainder unit
   localparam int CNT_W   = $clog2(NB);

   // Controller to datapath
   typedef struct packed {
      logic load;       // latch a new item, divisor 3
      logic div_start;  // clear remainder, reload dividend shifter
      logic div_step;   // one restoring remainder bit
      logic next_div;   // advance divisor by two, update its square
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic neg;        // sign bit set
      logic lt2;        // value is zero or one
      logic two;        // value is two
      logic even;       // low bit clear
      logic sq_gt_n;    // divisor squared exceeds value
      logic rem_zero;   // remainder is zero
      logic div_last;   // current step is the last remainder bit
   } status_type;

endpackage

// ===== hw/rtl/tdp_datapath.sv =====
// Datapath of the trial division prime test: value, odd divisor, running
// square of the divisor and a bit-serial restoring remainder unit.
// Depends on tdp_pkg.
module tdp_datapath
   import tdp_pkg::*;
(
   input  logic               clock,
   input  logic [VALUE_W-1:0] value,
   input  cmd_type            cmd,
   output status_type         status
);

   logic [WIDTH+VALUE_W-1:0] raw_wide;
   logic [WIDTH-1:0]         raw;

   logic             neg_ff,   neg_in;
   logic [NB-1:0]    n_ff,     n_in;
   logic [D_W-1:0]   d_ff,     d_in;
   logic [WIDTH-1:0] sq_ff,    sq_in;
   logic [D_W-1:0]   rem_ff,   rem_in;
   logic [NB-1:0]    shift_ff, shift_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;

   logic [D_W:0]     sh;
   logic [D_W:0]     diff;
   logic             ge;

   // Low WIDTH bits of the port, zero-extended where WIDTH is wider
   assign raw_wide = {{WIDTH{1'b0}}, value};
   assign raw      = raw_wide[WIDTH-1:0];

   // One remainder bit: shift in the next dividend bit, subtract if it fits
   assign sh   = {rem_ff, shift_ff[NB-1]};
   assign diff = sh - {1'b0, d_ff};
   assign ge   = sh >= {1'b0, d_ff};

   // Next-state logic
   always_comb begin
      neg_in   = neg_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         neg_in = raw[WIDTH-1];
         n_in   = raw[NB-1:0];
         d_in   = D_W'(3);
         sq_in  = WIDTH'(9);
      end
      if (cmd.div_start) begin
         rem_in   = '0;
         shift_in = n_ff;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in   = ge ? diff[D_W-1:0] : sh[D_W-1:0];
         shift_in = {shift_ff[NB-2:0], 1'b0};
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      // (d+2)^2 = d^2 + 4d + 4
      if (cmd.next_div) begin
         d_in  = d_ff + D_W'(2);
         sq_in = sq_ff + (WIDTH'(d_ff) << 2) + WIDTH'(4);
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   // Status back to the controller
   assign status.neg      = neg_ff;
   assign status.lt2      = n_ff < NB'(2);
   assign status.two      = n_ff == NB'(2);
   assign status.even     = ~n_ff[0];
   assign status.sq_gt_n  = sq_ff > WIDTH'(n_ff);
   assign status.rem_zero = rem_ff == '0;
   assign status.div_last = cnt_ff == CNT_W'(NB - 1);

endmodule

// ===== hw/rtl/tdp_ctrl.sv =====
// Controller of the trial division prime test: sequences the special-case
// checks, each remainder pass and the result strobe.
// Depends on tdp_pkg.
module tdp_ctrl
   import tdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd,
   output logic       rsp_valid,
   output logic       rsp_prime
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LOOP,
      S_DIV,
      S_REM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_prime_ff, rsp_prime_in;

   // Next state, commands and result
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_prime_in = rsp_prime_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         // negative, zero, one and even values other than two: not prime; two: prime
         S_CHECK: begin
            priority if (status.neg || status.lt2 || (status.even && !status.two)) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b0;
               state_in     = S_IDLE;
            end else if (status.two) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_LOOP;
            end
         end
         // no divisor up to the square root left: prime
         S_LOOP: begin
            if (status.sq_gt_n) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (status.rem_zero) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = 1'b0;
               state_in     = S_IDLE;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = S_LOOP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_prime_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_prime_ff <= rsp_prime_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = rsp_prime_ff;

`ifndef SYNTHESIS
   // An accepted item makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // The result strobe comes with the return to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // One strobe per item: a strobe is never followed directly by another
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A prime result never follows a zero remainder
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM && status.rem_zero) |=> (rsp_valid && !rsp_prime))
      else $error("zero remainder did not report composite");
`endif

endmodule

// ===== hw/rtl/trial_division_prime_test_top.sv =====
// Top level of the trial division prime test: controller and datapath.
// Depends on tdp_pkg, tdp_ctrl, tdp_datapath.
//
// channel   ports                    handshake
// input     req_value[31:0]          start && !busy
// result    rsp_prime                rsp_valid, one cycle, no stall
//
// Negative, zero, one, two and even values are settled in the check state.
// Otherwise each odd divisor d from 3 with d*d <= value is tried in turn
// until one divides it (setup, one remainder bit a cycle over WIDTH-1
// bits, and test); the result strobe is registered after the deciding
// state. Reset is synchronous and returns the controller to idle; the
// result receiver cannot stall, and a new item may start in the strobe cycle.
module trial_division_prime_test_top
   import tdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   output logic               rsp_prime
);

   cmd_type    cmd;
   status_type status;

   tdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_prime (rsp_prime)
   );

   tdp_datapath u_datapath (
      .clock  (clock),
      .value  (req_value),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for trial_division_prime_test_top: drives numbers
// through the start/busy port and checks each prime strobe in order.
// Depends on tdp_pkg and trial_division_prime_test_top.
module tb;
   import tdp_pkg::*;

   localparam int RANDOM_ITEMS = 100;
   localparam int QUIET_TAIL   = 20;        // last items sent back to back
   localparam int SETTLE       = 16;        // cycles to wait after the last result
   localparam int CYCLE_LIMIT  = 8_000_000;

   // one outstanding verdict, kept with its number for the report
   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 prime;
   } verdict_type;

   // directed row: verdict typed in where it is obvious, else predicted
   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 known;
      bit                 prime;
   } probe_type;

   localparam int NUM_PROBES = 21;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               busy;
   logic               rsp_valid;
   logic               rsp_prime;

   verdict_type pending_verdicts[$];
   verdict_type head;
   int          accepted    = 0;
   int          checked     = 0;
   int          primes_seen = 0;
   int          mismatches  = 0;
   int          cycles      = 0;

   probe_type probes [NUM_PROBES] = '{
      '{32'd0,           1'b1, 1'b0},   // zero
      '{32'd1,           1'b1, 1'b0},   // one
      '{32'd2,           1'b1, 1'b1},   // two, the only even prime
      '{32'd5,           1'b1, 1'b1},   // five, despite its last digit
      '{32'h8000_0000,   1'b1, 1'b0},   // most negative
      '{32'hFFFF_FFFF,   1'b1, 1'b0},   // minus one
      '{32'h7FFF_FFFE,   1'b1, 1'b0},   // largest even
      '{32'd3,           1'b0, 1'b0},
      '{32'd4,           1'b0, 1'b0},
      '{32'd7,           1'b0, 1'b0},
      '{32'd9,           1'b0, 1'b0},
      '{32'd10,          1'b0, 1'b0},
      '{32'd14,          1'b0, 1'b0},
      '{32'd15,          1'b0, 1'b0},
      '{32'd25,          1'b0, 1'b0},
      '{32'd49,          1'b0, 1'b0},   // divisor squared equals value
      '{32'd97,          1'b0, 1'b0},
      '{32'd121,         1'b0, 1'b0},
      '{32'd65521,       1'b0, 1'b0},
      '{32'h7FFF_FFFD,   1'b0, 1'b0},   // large, ends in 5
      '{32'h7FFF_FFFF,   1'b0, 1'b0}    // largest positive, full divisor sweep
   };

   trial_division_prime_test_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_prime (rsp_prime)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // primality of the low WIDTH bits, sign bit set means not prime
   function automatic bit predict_prime(logic [VALUE_W-1:0] v);
      longint unsigned n;
      longint unsigned d;
      n = 64'(v) & ((64'd1 << WIDTH) - 64'd1);
      if (((n >> (WIDTH - 1)) & 64'd1) != 0) return 1'b0;
      if (n < 2) return 1'b0;
      if (n == 2 || n == 5) return 1'b1;
      // last decimal digit even or five
      if ((n % 2) == 0 || (n % 10) == 5) return 1'b0;
      for (d = 3; d <= n / d; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // mostly values that reach trial division, sizes kept cheap
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned        pick;
      int unsigned        q;
      logic [VALUE_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         v = $urandom;
         v[WIDTH-1] = 1'b1;
      end else if (pick < 50) begin
         v = $urandom_range(0, 32767);
         if (pick % 4 != 0) v[0] = 1'b1;
      end else if (pick < 70) begin
         v = $urandom_range(32768, 262143);
         v[0] = 1'b1;
      end else if (pick < 88) begin
         // large, but with a factor of three so it ends quickly
         v = $urandom;
         v[WIDTH-1] = 1'b0;
         v = v - (v % 3);
      end else begin
         // odd square: a divisor no larger than the root divides it
         q = 2 * $urandom_range(1, 180) + 1;
         v = q * q;
      end
      return v;
   endfunction

   // present one item, optionally after an idle burst, and log its verdict
   task automatic submit(input logic [VALUE_W-1:0] v, input bit known,
                         input bit verdict, input bit allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_verdicts.push_back('{value: v, prime: known ? verdict : predict_prime(v)});
      accepted++;
   endtask

   // stop offering items, then wait for every outstanding verdict
   task automatic drain_results();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // result checker: strobes come in item order
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with nothing outstanding, prime=%0b", $time, rsp_prime);
            mismatches++;
         end else begin
            head = pending_verdicts.pop_front();
            checked++;
            if (rsp_prime === 1'b1) primes_seen++;
            if (rsp_prime !== head.prime) begin
               $display("%0t: value %0d (0x%08h) expected prime=%0b actual %0b",
                        $time, $signed(head.value), head.value, head.prime, rsp_prime);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
               $time, cycles, pending_verdicts.size());
      $display("== FAIL ==");
      $finish;
   end

   // stimulus
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (probes[i]) begin
         submit(probes[i].value, probes[i].known, probes[i].prime, 1'b1);
      end
      drain_results();

      // random items, one full drain halfway, no idling at the tail
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) drain_results();
         submit(random_value(), 1'b0, 1'b0, k < RANDOM_ITEMS - QUIET_TAIL);
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d numbers (%0d directed, incl. sign, zero, one, two, five and 2^31-1).",
               accepted, NUM_PROBES);
      $display("Checked %0d verdicts, %0d prime, %0d mismatches.",
               checked, primes_seen, mismatches);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
